// File: src/npsd_pkg.sv
`default_nettype none

package npsd_pkg;

    // Store geometry
    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 10;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PT_W   = 2 * COORD_BITS;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = 2 * COORD_BITS + 1;

    // Fixed port widths
    localparam int CMD_W      = 2;
    localparam int IN_COORD_W = 10;
    localparam int OUT_IDX_W  = 10;
    localparam int OUT_DIST_W = 21;
    localparam int STAT_W     = 2;
    localparam int SAT_W      = (DIST_W > OUT_DIST_W) ? DIST_W : OUT_DIST_W;

    localparam logic [OUT_DIST_W-1:0] OUT_DIST_MAX = {OUT_DIST_W{1'b1}};

    typedef logic [CMD_W-1:0]      t_cmd;
    typedef logic [STAT_W-1:0]     t_status;
    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [PT_W-1:0]       t_point;
    typedef logic [SQ_W-1:0]       t_sq;
    typedef logic [DIST_W-1:0]     t_dist;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    // Commands
    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_QUERY  = 2'd1;
    localparam t_cmd CMD_CLEAR  = 2'd2;

    // Result status
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // Tag that follows one stored point down the distance pipeline
    typedef struct packed {
        logic vld;
        logic last;
        t_idx idx;
    } t_tag;

    // Clamp a distance to the result field
    function automatic logic [OUT_DIST_W-1:0] sat_dist(input t_dist d);
        logic [SAT_W-1:0] w;
        w = SAT_W'(d);
        if (w > SAT_W'(OUT_DIST_MAX)) begin
            return OUT_DIST_MAX;
        end else begin
            return OUT_DIST_W'(w);
        end
    endfunction

endpackage

`default_nettype wire

// File: src/npsd_ram.sv
`default_nettype none

module npsd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/npsd_dist.sv
`default_nettype none

module npsd_dist
    import npsd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_coord i_qx,
    input  wire t_coord i_qy,
    input  wire t_point i_point,
    input  wire t_tag   i_tag,
    output t_dist       o_dist,
    output t_tag        o_tag
);

    t_coord w_ex;
    t_coord w_ey;

    t_coord r_dx, n_dx;
    t_coord r_dy, n_dy;
    t_sq    r_sqx, n_sqx;
    t_sq    r_sqy, n_sqy;
    t_dist  r_dist, n_dist;
    t_tag   r_tag1, r_tag2, r_tag3;

    assign w_ex = i_point[COORD_BITS-1:0];
    assign w_ey = i_point[PT_W-1:COORD_BITS];

    // Absolute differences, squares, then the sum
    always_comb begin
        n_dx   = (w_ex >= i_qx) ? (w_ex - i_qx) : (i_qx - w_ex);
        n_dy   = (w_ey >= i_qy) ? (w_ey - i_qy) : (i_qy - w_ey);
        n_sqx  = SQ_W'(r_dx) * SQ_W'(r_dx);
        n_sqy  = SQ_W'(r_dy) * SQ_W'(r_dy);
        n_dist = DIST_W'(r_sqx) + DIST_W'(r_sqy);
    end

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_sqx  <= n_sqx;
        r_sqy  <= n_sqy;
        r_dist <= n_dist;
    end

    // Advance the tags alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.vld <= 1'b0;
            r_tag2.vld <= 1'b0;
            r_tag3.vld <= 1'b0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    assign o_dist = r_dist;
    assign o_tag  = r_tag3;

endmodule

`default_nettype wire

// File: src/nearest_point_search_2d_core.sv
// Insert, clear and unused commands: result strobe in the cycle after the item is accepted.
// Query: strobe after RAM read, diff, square and sum registers (empty: as insert);
// the scan reads one stored point per cycle from the point RAM's single read port.
// busy is high for the whole scan; results cannot be stalled and show for one cycle.
// Reset clears the point count and control state; store contents are left as they are,
// with no clearing pass, since only entries below the count are ever used.
`default_nettype none

module nearest_point_search_2d_core
    import npsd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [IN_COORD_W-1:0] i_x_coord,
    input  wire logic [IN_COORD_W-1:0] i_y_coord,
    output logic                       o_valid,
    output logic [OUT_IDX_W-1:0]       o_node_index,
    output logic [OUT_DIST_W-1:0]      o_dist_sq,
    output logic [STAT_W-1:0]          o_status
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic r_state, n_state;
    t_cnt r_count, n_count;
    t_coord r_qx, n_qx;
    t_coord r_qy, n_qy;
    t_idx r_rd_addr, n_rd_addr;
    logic r_issuing, n_issuing;
    t_tag r_rd_tag, n_rd_tag;
    logic r_have, n_have;
    t_dist r_best, n_best;
    t_idx r_best_idx, n_best_idx;

    logic r_out_valid, n_out_valid;
    logic [OUT_IDX_W-1:0] r_out_idx, n_out_idx;
    logic [OUT_DIST_W-1:0] r_out_dist, n_out_dist;
    t_status r_out_status, n_out_status;

    logic   w_accept;
    logic   w_we;
    t_idx   w_waddr;
    t_point w_wdata;
    t_coord w_px;
    t_coord w_py;
    t_point w_rdata;
    t_dist  w_dist;
    t_tag   w_tag;
    logic   w_is_last;
    logic   w_take;
    t_dist  w_sel_dist;
    t_idx   w_sel_idx;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_px     = t_coord'(i_x_coord);
    assign w_py     = t_coord'(i_y_coord);
    assign w_waddr  = r_count[IDX_W-1:0];
    assign w_wdata  = {w_py, w_px};
    assign w_is_last = ((CNT_W'(r_rd_addr) + CNT_W'(1)) == r_count);

    npsd_ram #(
        .WIDTH(PT_W),
        .DEPTH(MAX_POINTS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_rd_addr),
        .o_rdata(w_rdata)
    );

    npsd_dist u_dist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_qx   (r_qx),
        .i_qy   (r_qy),
        .i_point(w_rdata),
        .i_tag  (r_rd_tag),
        .o_dist (w_dist),
        .o_tag  (w_tag)
    );

    // Keep the running minimum; a tie keeps the earlier index
    always_comb begin
        w_take     = w_tag.vld && (!r_have || (w_dist < r_best));
        w_sel_dist = w_take ? w_dist : r_best;
        w_sel_idx  = w_take ? w_tag.idx : r_best_idx;
    end

    // Sequence commands and the scan
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_qx         = r_qx;
        n_qy         = r_qy;
        n_rd_addr    = r_rd_addr;
        n_issuing    = r_issuing;
        n_rd_tag     = r_rd_tag;
        n_rd_tag.vld = 1'b0;
        n_have       = r_have;
        n_best       = r_best;
        n_best_idx   = r_best_idx;
        n_out_valid  = 1'b0;
        n_out_idx    = r_out_idx;
        n_out_dist   = r_out_dist;
        n_out_status = r_out_status;
        w_we         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = '0;
                    n_out_dist   = '0;
                    n_out_status = ST_OK;
                    unique case (i_cmd)
                        CMD_INSERT: begin
                            if (r_count >= CNT_W'(MAX_POINTS)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                w_we      = 1'b1;
                                n_out_idx = OUT_IDX_W'(r_count);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        CMD_QUERY: begin
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_SCAN;
                                n_qx        = w_px;
                                n_qy        = w_py;
                                n_rd_addr   = '0;
                                n_issuing   = 1'b1;
                                n_have      = 1'b0;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Issue one read per cycle until the last stored point
                if (r_issuing) begin
                    n_rd_tag.vld  = 1'b1;
                    n_rd_tag.last = w_is_last;
                    n_rd_tag.idx  = r_rd_addr;
                    n_rd_addr     = r_rd_addr + IDX_W'(1);
                    n_issuing     = !w_is_last;
                end
                // Fold each distance into the best so far
                if (w_tag.vld) begin
                    n_have     = 1'b1;
                    n_best     = w_sel_dist;
                    n_best_idx = w_sel_idx;
                end
                // Report once the last point has been compared
                if (w_tag.vld && w_tag.last) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_idx    = OUT_IDX_W'(w_sel_idx);
                    n_out_dist   = sat_dist(w_sel_dist);
                    n_out_status = ST_OK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_issuing    <= 1'b0;
            r_rd_tag.vld <= 1'b0;
            r_have       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issuing   <= n_issuing;
            r_rd_tag    <= n_rd_tag;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_qx         <= n_qx;
        r_qy         <= n_qy;
        r_rd_addr    <= n_rd_addr;
        r_best       <= n_best;
        r_best_idx   <= n_best_idx;
        r_out_idx    <= n_out_idx;
        r_out_dist   <= n_out_dist;
        r_out_status <= n_out_status;
    end

    assign o_valid      = r_out_valid;
    assign o_node_index = r_out_idx;
    assign o_dist_sq    = r_out_dist;
    assign o_status     = r_out_status;

    // A result always lands with the block idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // The count never passes the store depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    // Distances only arrive during a scan
    a_tag_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tag.vld |-> (r_state == S_SCAN))
        else $error("distance pipeline active outside a scan");

    // Every command but a query answers on the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd != CMD_QUERY)) |=> o_valid)
        else $error("missing result after non-query item");

    // No read is issued while idle
    a_no_issue_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_issuing)
        else $error("scan read pending while idle");

endmodule

`default_nettype wire
